>>> rtl/ordered_list_table_core_defines.svh
// ----------------------------------------------------------------------------
// Ordered list table assertion macros
// Shared concurrent assertion forms for the ordered list table core.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_TABLE_CORE_DEFINES_SVH
`define ORDERED_LIST_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define OLT_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("olt: implication check failed");

// next-cycle implication
`define OLT_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("olt: next-cycle check failed");

`endif

>>> rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list table package
// Field widths, operation and status codes, request and result types.
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int FUNC_W = 3;
    localparam int POS_W  = 4;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 5;
    localparam int STAT_W = 2;

    localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RESIZE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POS  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
        logic [LEN_W-1:0]         new_length;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic [LEN_W-1:0]         length;
        logic [STAT_W-1:0]        status;
    } result_t;

endpackage

>>> rtl/olt_ram.sv
// ----------------------------------------------------------------------------
// Ordered list table entry store
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module olt_ram
    import olt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/olt_seq.sv
// ----------------------------------------------------------------------------
// Ordered list table sequencer
// Decodes a request and walks the entry store one entry a cycle.
// ----------------------------------------------------------------------------
`include "ordered_list_table_core_defines.svh"

module olt_seq
    import olt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  req_t                     req,
    output logic                     res_valid,
    input  logic                     res_ready,
    output result_t                  res,
    output logic                     ram_we,
    output logic [IDX_W-1:0]         ram_waddr,
    output logic signed [DATA_W-1:0] ram_wdata,
    output logic                     ram_re,
    output logic [IDX_W-1:0]         ram_raddr,
    input  logic signed [DATA_W-1:0] ram_rdata
);

    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b00_0000_0001,
        ST_IDLE     = 10'b00_0000_0010,
        ST_DECODE   = 10'b00_0000_0100,
        ST_RD_WAIT  = 10'b00_0000_1000,
        ST_SHIFT_UP = 10'b00_0001_0000,
        ST_PLACE    = 10'b00_0010_0000,
        ST_SHIFT_DN = 10'b00_0100_0000,
        ST_TOP      = 10'b00_1000_0000,
        ST_ZERO     = 10'b01_0000_0000,
        ST_DONE     = 10'b10_0000_0000
    } state_t;

    state_t                   state_reg,  state_next;
    req_t                     req_reg,    req_next;
    logic [CNT_W-1:0]         used_reg,   used_next;
    logic [IDX_W-1:0]         ptr_reg,    ptr_next;
    logic signed [DATA_W-1:0] rdata_reg,  rdata_next;
    logic [STAT_W-1:0]        status_reg, status_next;

    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] used_c;
    logic [CMP_W-1:0] nlen_c;
    logic [CMP_W-1:0] ptr_c;
    logic [CMP_W-1:0] depth_c;
    logic             pos_ok;

    assign pos_c   = CMP_W'(req_reg.position);
    assign used_c  = CMP_W'(used_reg);
    assign nlen_c  = CMP_W'(req_reg.new_length);
    assign ptr_c   = CMP_W'(ptr_reg);
    assign depth_c = CMP_W'(DEPTH);
    assign pos_ok  = pos_c < used_c;

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        used_next   = used_reg;
        ptr_next    = ptr_reg;
        rdata_next  = rdata_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = ptr_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (ptr_reg == IDX_W'(DEPTH - 1)) begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (req_valid) begin
                    req_next    = req;
                    rdata_next  = '0;
                    status_next = STAT_OK;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_DONE;
                case (req_reg.func)
                    FN_READ: begin
                        if (pos_ok) begin
                            ram_re     = 1'b1;
                            ram_raddr  = IDX_W'(req_reg.position);
                            state_next = ST_RD_WAIT;
                        end else begin
                            status_next = STAT_POS;
                        end
                    end
                    FN_WRITE: begin
                        if (pos_ok) begin
                            ram_we    = 1'b1;
                            ram_waddr = IDX_W'(req_reg.position);
                            ram_wdata = req_reg.value;
                        end else begin
                            status_next = STAT_POS;
                        end
                    end
                    FN_INSERT: begin
                        if (used_c >= depth_c) begin
                            status_next = STAT_FULL;
                        end else if (!pos_ok) begin
                            ram_we    = 1'b1;
                            ram_waddr = IDX_W'(used_reg);
                            ram_wdata = req_reg.value;
                            used_next = used_reg + 1'b1;
                        end else begin
                            ram_re     = 1'b1;
                            ram_raddr  = IDX_W'(used_c - CMP_W'(1));
                            ptr_next   = IDX_W'(used_reg);
                            state_next = ST_SHIFT_UP;
                        end
                    end
                    FN_DELETE: begin
                        if (!pos_ok) begin
                            status_next = STAT_POS;
                        end else if (pos_c + CMP_W'(1) < used_c) begin
                            ram_re     = 1'b1;
                            ram_raddr  = IDX_W'(pos_c + CMP_W'(1));
                            ptr_next   = IDX_W'(req_reg.position);
                            state_next = ST_SHIFT_DN;
                        end else begin
                            state_next = ST_TOP;
                        end
                    end
                    FN_RESIZE: begin
                        if (nlen_c > depth_c) begin
                            status_next = STAT_POS;
                        end else if (used_c < nlen_c) begin
                            ptr_next   = IDX_W'(used_reg);
                            state_next = ST_ZERO;
                        end else begin
                            used_next = CNT_W'(req_reg.new_length);
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RD_WAIT: begin
                rdata_next = ram_rdata;
                state_next = ST_DONE;
            end
            ST_SHIFT_UP: begin
                ram_we = 1'b1;
                if (ptr_c == pos_c + CMP_W'(1)) begin
                    state_next = ST_PLACE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = IDX_W'(ptr_c - CMP_W'(2));
                    ptr_next  = ptr_reg - 1'b1;
                end
            end
            ST_PLACE: begin
                ram_we     = 1'b1;
                ram_waddr  = IDX_W'(req_reg.position);
                ram_wdata  = req_reg.value;
                used_next  = used_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_SHIFT_DN: begin
                ram_we = 1'b1;
                if (ptr_c + CMP_W'(2) < used_c) begin
                    ram_re    = 1'b1;
                    ram_raddr = IDX_W'(ptr_c + CMP_W'(2));
                    ptr_next  = ptr_reg + 1'b1;
                end else begin
                    state_next = ST_TOP;
                end
            end
            ST_TOP: begin
                ram_we     = 1'b1;
                ram_waddr  = IDX_W'(used_c - CMP_W'(1));
                ram_wdata  = '0;
                used_next  = used_reg - 1'b1;
                state_next = ST_DONE;
            end
            ST_ZERO: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (ptr_c + CMP_W'(1) == nlen_c) begin
                    used_next  = CNT_W'(req_reg.new_length);
                    state_next = ST_DONE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            used_reg  <= '0;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        rdata_reg  <= rdata_next;
        status_reg <= status_next;
    end

    assign req_ready     = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_DONE);
    assign res.read_data = rdata_reg;
    assign res.length    = LEN_W'(used_reg);
    assign res.status    = status_reg;

    `OLT_ASSERT_NXT(a_accept_decode, aclk, aresetn, req_valid && req_ready, state_reg == ST_DECODE)
    `OLT_ASSERT_IMP(a_used_bound, aclk, aresetn, 1'b1, used_c <= depth_c)
    `OLT_ASSERT_IMP(a_zero_fill, aclk, aresetn, ram_we && (state_reg == ST_CLEAR || state_reg == ST_ZERO || state_reg == ST_TOP), ram_wdata == '0)
    `OLT_ASSERT_NXT(a_res_hold, aclk, aresetn, res_valid && !res_ready, res_valid && $stable(res))

endmodule

>>> rtl/ordered_list_table_core.sv
// Flow: an accepted word is decoded and its result then loaded into the output register;
// a read first waits for the entry store, an insert before the end first moves entries up
// one at a time, a delete clears the top entry after moving any entries above the position
// down one at a time, and a growing resize first clears the new entries one at a time.
// Throughput: one request at a time; s_tready is low from acceptance until the result is
// handed over, so no word is accepted before the last one is through.
// Reset: synchronous; after aresetn the store is zeroed one entry a cycle, taking no word.
// ----------------------------------------------------------------------------
// Ordered list table core
// Bounded ordered list of signed words with read, write, insert, delete and resize.
// ----------------------------------------------------------------------------
module ordered_list_table_core
    import olt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // position[3:0], value[35:4], new_length[40:36], zero pad
    input  logic [2:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_data[31:0], length[36:32], zero pad
    output logic [1:0]  m_tuser    // status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    req_t                     req;
    result_t                  res;
    logic                     res_valid;
    logic                     res_ready;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic signed [DATA_W-1:0] ram_wdata;
    logic                     ram_re;
    logic [IDX_W-1:0]         ram_raddr;
    logic signed [DATA_W-1:0] ram_rdata;

    result_t out_reg;
    logic    out_valid_reg;

    assign req.func       = s_tuser;
    assign req.position   = s_tdata[3:0];
    assign req.value      = s_tdata[35:4];
    assign req.new_length = s_tdata[40:36];

    olt_seq #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    olt_ram #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // output word register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.length, out_reg.read_data};
    assign m_tuser  = out_reg.status;

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Ordered list table core testbench
// Drives read, write, insert, delete, resize and unused function code requests over the input stream,
// mirrors the list in a scoreboard and checks every result word field by field.
// Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import olt_pkg::*;

    localparam int LIST_DEPTH = 16;

    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;

    localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_ONES = 32'hffff_ffff;

    class list_mirror;
        logic [DATA_W-1:0] store [LIST_DEPTH];
        int unsigned       used;
        result_t           pending_results [$];
        int                failures;

        function new();
            foreach (store[i]) store[i] = '0;
            used     = 0;
            failures = 0;
        endfunction

        function void apply_request(req_t rq);
            result_t     res;
            int unsigned p;
            int unsigned n;
            res = '0;
            p   = 32'(rq.position);
            n   = 32'(rq.new_length);
            case (rq.func)
                FN_READ: begin
                    if (p < used) res.read_data = store[p];
                    else res.status = STAT_POS;
                end
                FN_WRITE: begin
                    if (p < used) store[p] = rq.value;
                    else res.status = STAT_POS;
                end
                FN_INSERT: begin
                    if (used >= LIST_DEPTH) begin
                        res.status = STAT_FULL;
                    end else begin
                        if (p >= used) begin
                            store[used] = rq.value;
                        end else begin
                            for (int unsigned i = used; i > p; i--) store[i] = store[i-1];
                            store[p] = rq.value;
                        end
                        used++;
                    end
                end
                FN_DELETE: begin
                    if (p < used) begin
                        for (int unsigned i = p; i + 1 < used; i++) store[i] = store[i+1];
                        store[used-1] = '0;
                        used--;
                    end else begin
                        res.status = STAT_POS;
                    end
                end
                FN_RESIZE: begin
                    if (n > LIST_DEPTH) begin
                        res.status = STAT_POS;
                    end else begin
                        for (int unsigned i = used; i < n; i++) store[i] = '0;
                        used = n;
                    end
                end
                default: ;
            endcase
            res.length = used[LEN_W-1:0];
            pending_results.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result word data=%h len=%0d stat=%0d",
                             $realtime, got.read_data, got.length, got.status);
                return;
            end
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data || got.length !== want.length ||
                got.status !== want.status) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch exp data=%h len=%0d stat=%0d, got data=%h len=%0d stat=%0d",
                             $realtime, want.read_data, want.length, want.status,
                             got.read_data, got.length, got.status);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // position[3:0], value[35:4], new_length[40:36], zero pad
    logic [2:0]  s_tuser  = '0;   // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // read_data[31:0], length[36:32], zero pad
    logic [1:0]  m_tuser;         // status

    list_mirror mirror;
    int         burst_left = 0;

    ordered_list_table_core #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: rotating ready mask, reloaded now and then
    always @(posedge aclk) begin : ready_pattern
        static logic [31:0] ready_mask = '1;
        static int          ready_hold = 0;
        if (ready_hold == 0) begin
            ready_hold = $urandom_range(40, 400);
            case ($urandom_range(0, 3))
                0:       ready_mask = '1;
                1:       ready_mask = $urandom | 32'h1;
                2:       ready_mask = 32'h0001_0001;
                default: ready_mask = $urandom | $urandom;
            endcase
        end
        ready_hold--;
        ready_mask = {ready_mask[0], ready_mask[31:1]};
        m_tready <= ready_mask[0];
    end

    always @(posedge aclk) begin : result_check
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.read_data = m_tdata[31:0];
            got.length    = m_tdata[36:32];
            got.status    = m_tuser;
            mirror.check_result(got);
        end
    end

    task automatic send_req(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] val, input logic [LEN_W-1:0] nlen);
        req_t rq;
        int   gap;
        rq.func       = fn;
        rq.position   = pos;
        rq.value      = val;
        rq.new_length = nlen;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, nlen, val, pos};
        s_tuser  <= fn;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mirror.apply_request(rq);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid   <= 1'b0;
            gap        = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (mirror.pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return WORD_ONES;
            3:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t random_request(bit growing, int unsigned len);
        req_t rq;
        int   pick;
        rq.value      = random_word();
        rq.position   = POS_W'($urandom_range(0, 15));
        rq.new_length = ($urandom_range(0, 6) == 0) ? LEN_W'($urandom_range(17, 31))
                                                    : LEN_W'($urandom_range(0, LIST_DEPTH));
        pick = $urandom_range(0, 99);
        if (pick < 18)                    rq.func = FN_READ;
        else if (pick < 33)               rq.func = FN_WRITE;
        else if (pick < (growing ? 73 : 48)) rq.func = FN_INSERT;
        else if (pick < 89)               rq.func = FN_DELETE;
        else if (pick < 96)               rq.func = FN_RESIZE;
        else                              rq.func = FN_SPARE_A + FUNC_W'($urandom_range(0, 2));
        if (rq.func == FN_INSERT) begin
            if ($urandom_range(0, 3) != 0) rq.position = POS_W'($urandom_range(0, len));
        end else if (len > 0 && $urandom_range(0, 3) != 0) begin
            rq.position = POS_W'($urandom_range(0, len - 1));
        end
        return rq;
    endfunction

    initial begin : stimulus
        req_t rq;
        bit   growing;
        int   phase_left;
        mirror = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list, out of range requests
        send_req(FN_READ,   4'd0,  WORD_ONES, 5'd0);
        send_req(FN_DELETE, 4'd0,  WORD_ONES, 5'd0);
        send_req(FN_WRITE,  4'd0,  WORD_MAX,  5'd0);
        send_req(FN_RESIZE, 4'd15, '0,        5'd17);
        send_req(FN_RESIZE, 4'd0,  '0,        5'd31);
        // full list
        send_req(FN_RESIZE, 4'd0,  '0,        5'd16);
        send_req(FN_READ,   4'd15, '0,        5'd0);
        send_req(FN_WRITE,  4'd15, WORD_MAX,  5'd0);
        send_req(FN_WRITE,  4'd0,  WORD_MIN,  5'd0);
        send_req(FN_INSERT, 4'd3,  WORD_ONES, 5'd0);
        send_req(FN_READ,   4'd15, '0,        5'd0);
        send_req(FN_DELETE, 4'd15, '0,        5'd0);
        send_req(FN_DELETE, 4'd0,  '0,        5'd0);
        send_req(FN_READ,   4'd0,  '0,        5'd0);
        // shrink then grow: hidden entries come back cleared
        send_req(FN_RESIZE, 4'd0,  '0,        5'd3);
        send_req(FN_READ,   4'd5,  '0,        5'd0);
        send_req(FN_RESIZE, 4'd0,  '0,        5'd8);
        send_req(FN_READ,   4'd5,  '0,        5'd0);
        send_req(FN_INSERT, 4'd15, WORD_ONES, 5'd0);
        send_req(FN_INSERT, 4'd0,  32'h5a5a_a5a5, 5'd0);
        send_req(FN_SPARE_A, 4'd1, WORD_ONES, 5'd31);
        send_req(FN_SPARE_B, 4'd2, WORD_MIN,  5'd16);
        send_req(FN_SPARE_C, 4'd9, WORD_MAX,  5'd1);
        send_req(FN_RESIZE, 4'd0,  '0,        5'd0);
        send_req(FN_INSERT, 4'd15, 32'd1,     5'd0);
        drain_results();

        growing    = 1'b1;
        phase_left = $urandom_range(30, 120);
        for (int n = 0; n < 1390; n++) begin
            if (phase_left == 0) begin
                growing    = !growing;
                phase_left = $urandom_range(30, 120);
            end
            phase_left--;
            rq = random_request(growing, mirror.used);
            send_req(rq.func, rq.position, rq.value, rq.new_length);
            if (n % 300 == 299) drain_results();
        end

        drain_results();
        repeat (LIST_DEPTH + 8) @(posedge aclk);
        if (mirror.failures == 0 && mirror.pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
